>>> src/bounded_undo_redo_history_macros.svh
// Assertion macros for the bounded undo/redo history.
// Included by the top level; needs nothing else.
`ifndef BOUNDED_UNDO_REDO_HISTORY_MACROS_SVH
`define BOUNDED_UNDO_REDO_HISTORY_MACROS_SVH

// Same-cycle implication under reset
`define BURH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under reset
`define BURH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/burh_pkg.sv
// Shared types and constants for the bounded undo/redo history.
// No dependencies.
package burh_pkg;

    // Fixed field widths of the stream interface
    localparam int KIND_BITS    = 4;
    localparam int PAYLOAD_BITS = 32;
    localparam int MODE_BITS    = 3;
    localparam int IN_TDATA_W   = 40;

    // Command codes carried in tuser
    typedef enum logic [MODE_BITS-1:0] {
        MODE_PUSH       = 3'd0,
        MODE_UNDO       = 3'd1,
        MODE_REDO       = 3'd2,
        MODE_MARK_CLEAN = 3'd3,
        MODE_CLEAR      = 3'd4,
        MODE_INVALIDATE = 3'd5,
        MODE_QUERY      = 3'd6
    } mode_t;

endpackage

>>> src/burh_ram.sv
// Generic RAM: one write port, two registered read ports sharing a read enable.
// No dependencies.
module burh_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered reads, held while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

>>> src/bounded_undo_redo_history.sv
// Bounded undo/redo history, top level. Uses burh_pkg, burh_ram and the macro header.
// A command's result passes the history RAM read, then the output register. Throughput:
// one command per cycle while the result stream is not stalled, set by the RAM's single
// write port and registered read ports. Reset (rst_n low, async) empties the history,
// puts cursor and clean mark at zero with the mark valid; RAM contents are not cleared
// and need no clearing pass, since only written entries ever reach a result.
`include "bounded_undo_redo_history_macros.svh"

module bounded_undo_redo_history #(
    parameter int DEPTH         = 64,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Command stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: entry_kind[3:0], entry_payload[35:4], zero pad
    input  logic [burh_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser: mode[2:0]
    input  logic [burh_pkg::MODE_BITS-1:0]       s_axis_tuser,
    // Result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: op_ok, dirty, undo_depth, redo_depth, has_undo, undo_kind, undo_payload,
    //        has_redo, redo_kind, redo_payload, zero pad
    output logic [((76 + 2*$clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int CW       = $clog2(DEPTH + 1);
    localparam int AW       = $clog2(DEPTH);
    localparam int EW       = burh_pkg::KIND_BITS + PAYLOAD_WIDTH;
    localparam int OUT_W    = ((76 + 2*CW + 7) / 8) * 8;

    // Logical position to physical RAM address (ring offset)
    function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] base,
                                                input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(pos);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // History state
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] mark_reg, mark_next;
    logic          mark_valid_reg, mark_valid_next;
    logic [AW-1:0] base_reg, base_next;

    // Read stage
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_ok_reg, s1_ok_next;
    logic          s1_dirty_reg, s1_dirty_next;
    logic [CW-1:0] s1_udepth_reg, s1_udepth_next;
    logic [CW-1:0] s1_rdepth_reg, s1_rdepth_next;
    logic          s1_has_u_reg, s1_has_u_next;
    logic          s1_has_r_reg, s1_has_r_next;
    logic          s1_bypass_reg, s1_bypass_next;
    logic [EW-1:0] s1_wdata_reg;

    // Output register
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    // Handshake and decode
    logic                       s1_adv, in_acc;
    burh_pkg::mode_t            mode;
    logic [burh_pkg::KIND_BITS-1:0] kind;
    logic [EW-1:0]              wr_entry;
    logic                       do_push, wr_en;
    logic [AW-1:0]              wr_addr, rd_addr_u, rd_addr_r;
    logic [CW-1:0]              undo_pos;
    logic                       ok;
    logic [EW-1:0]              rd_u, rd_r, undo_entry;
    logic [burh_pkg::KIND_BITS-1:0]    undo_kind, redo_kind;
    logic [burh_pkg::PAYLOAD_BITS-1:0] undo_pay, redo_pay;

    assign s1_adv        = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign mode     = burh_pkg::mode_t'(s_axis_tuser);
    assign kind     = s_axis_tdata[burh_pkg::KIND_BITS-1:0];
    assign wr_entry = {kind,
        PAYLOAD_WIDTH'(s_axis_tdata[burh_pkg::KIND_BITS +: burh_pkg::PAYLOAD_BITS])};
    assign do_push  = (mode == burh_pkg::MODE_PUSH) && (kind != '0);
    assign wr_en    = in_acc && do_push;
    // New entry goes at the cursor; at full the cursor maps onto the oldest slot
    assign wr_addr  = phys_addr(base_reg, cursor_reg);

    // Next history state for the command
    always_comb
    begin
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        mark_next       = mark_reg;
        mark_valid_next = mark_valid_reg;
        base_next       = base_reg;
        ok              = 1'b1;
        case (mode)
            burh_pkg::MODE_PUSH:
            begin
                if (do_push)
                begin
                    if (mark_valid_reg && (mark_reg > cursor_reg))
                    begin
                        mark_valid_next = 1'b0;
                    end
                    if (cursor_reg < CW'(DEPTH))
                    begin
                        count_next  = cursor_reg + CW'(1);
                        cursor_next = cursor_reg + CW'(1);
                    end
                    else
                    begin
                        // Full: drop oldest entry by moving the ring base
                        if (mark_valid_next)
                        begin
                            if (mark_reg == '0)
                            begin
                                mark_valid_next = 1'b0;
                            end
                            else
                            begin
                                mark_next = mark_reg - CW'(1);
                            end
                        end
                        base_next   = (base_reg == AW'(DEPTH - 1)) ? '0 : base_reg + AW'(1);
                        count_next  = CW'(DEPTH);
                        cursor_next = CW'(DEPTH);
                    end
                end
            end
            burh_pkg::MODE_UNDO:
            begin
                if (cursor_reg == '0)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    cursor_next = cursor_reg - CW'(1);
                end
            end
            burh_pkg::MODE_REDO:
            begin
                if (cursor_reg >= count_reg)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    cursor_next = cursor_reg + CW'(1);
                end
            end
            burh_pkg::MODE_MARK_CLEAN:
            begin
                mark_next       = cursor_reg;
                mark_valid_next = 1'b1;
            end
            burh_pkg::MODE_CLEAR:
            begin
                count_next      = '0;
                cursor_next     = '0;
                mark_next       = '0;
                mark_valid_next = 1'b1;
            end
            burh_pkg::MODE_INVALIDATE:
            begin
                count_next      = '0;
                cursor_next     = '0;
                mark_next       = '0;
                mark_valid_next = 1'b0;
            end
            default:
            begin
                ok = 1'b1;
            end
        endcase
    end

    // Read addresses and result flags from the post-command state
    always_comb
    begin
        s1_has_u_next  = (cursor_next != '0);
        s1_has_r_next  = (cursor_next < count_next);
        undo_pos       = s1_has_u_next ? (cursor_next - CW'(1)) : '0;
        rd_addr_u      = phys_addr(base_next, undo_pos);
        rd_addr_r      = phys_addr(base_next, cursor_next);
        s1_ok_next     = ok;
        s1_dirty_next  = !mark_valid_next || (cursor_next != mark_next);
        s1_udepth_next = cursor_next;
        s1_rdepth_next = count_next - cursor_next;
        // A push always lands on the slot read as the undo entry
        s1_bypass_next = do_push;
        s1_valid_next  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    end

    burh_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_entry),
        .rd_en     (in_acc),
        .rd_addr_a (rd_addr_u),
        .rd_addr_b (rd_addr_r),
        .rd_data_a (rd_u),
        .rd_data_b (rd_r)
    );

    // Result assembly from the read stage
    always_comb
    begin
        undo_entry   = s1_bypass_reg ? s1_wdata_reg : rd_u;
        undo_kind    = s1_has_u_reg ? undo_entry[EW-1:PAYLOAD_WIDTH] : '0;
        undo_pay     = s1_has_u_reg ? burh_pkg::PAYLOAD_BITS'(undo_entry[PAYLOAD_WIDTH-1:0]) : '0;
        redo_kind    = s1_has_r_reg ? rd_r[EW-1:PAYLOAD_WIDTH] : '0;
        redo_pay     = s1_has_r_reg ? burh_pkg::PAYLOAD_BITS'(rd_r[PAYLOAD_WIDTH-1:0]) : '0;
        m_tdata_next = OUT_W'({redo_pay, redo_kind, s1_has_r_reg,
                               undo_pay, undo_kind, s1_has_u_reg,
                               s1_rdepth_reg, s1_udepth_reg, s1_dirty_reg, s1_ok_reg});
        if (s1_valid_reg && s1_adv)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            cursor_reg     <= '0;
            mark_reg       <= '0;
            mark_valid_reg <= 1'b1;
            base_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                count_reg      <= count_next;
                cursor_reg     <= cursor_next;
                mark_reg       <= mark_next;
                mark_valid_reg <= mark_valid_next;
                base_reg       <= base_next;
            end
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_ok_reg     <= s1_ok_next;
            s1_dirty_reg  <= s1_dirty_next;
            s1_udepth_reg <= s1_udepth_next;
            s1_rdepth_reg <= s1_rdepth_next;
            s1_has_u_reg  <= s1_has_u_next;
            s1_has_r_reg  <= s1_has_r_next;
            s1_bypass_reg <= s1_bypass_next;
            s1_wdata_reg  <= wr_entry;
        end
        if (s1_valid_reg && s1_adv)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // Checks
    `BURH_ASSERT_NOW(a_cursor_in_range, clk, rst_n, 1'b1,
        (cursor_reg <= count_reg) && (count_reg <= CW'(DEPTH)), "cursor or count out of range")
    `BURH_ASSERT_NOW(a_mark_in_range, clk, rst_n, mark_valid_reg,
        mark_reg <= count_reg, "valid clean mark beyond stored entries")
    `BURH_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, in_acc,
        s1_valid_reg, "accepted command did not reach the read stage")

endmodule
